// ----- design/csdm_pkg.sv -----
// Shared constants, angle table and output rounding for the square-to-disk mapper.
`timescale 1ns / 1ps
package csdm_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int ROT_STAGES_DEF = 16;

    // Quotient bits of the ratio: magnitude goes up to one octant, 2^29.
    localparam int DIV_BITS = 30;
    localparam int ANG_BITS = 32;
    localparam int RAD_BITS = 30;
    // CORDIC datapath width, Q30 plus headroom for gain and sign.
    localparam int XW = 34;

    localparam logic [30:0] GAIN_COMP = 31'd1304065748;
    localparam logic [31:0] HALF_QUAD = 32'h2000_0000;

    localparam logic [1:0] SEC_EAST  = 2'd0;
    localparam logic [1:0] SEC_NORTH = 2'd1;
    localparam logic [1:0] SEC_WEST  = 2'd2;
    localparam logic [1:0] SEC_SOUTH = 2'd3;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    typedef logic signed [XW-1:0] cord_t;

    // Arctangent of 2^-i in binary-angle units (full turn is 2^32).
    function automatic logic [31:0] atan_bam(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051E;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2F;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2FA;
            5'd15:   val = 32'h0000517D;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A30;
            5'd19:   val = 32'h00000518;
            5'd20:   val = 32'h0000028C;
            5'd21:   val = 32'h00000146;
            5'd22:   val = 32'h000000A3;
            5'd23:   val = 32'h00000051;
            5'd24:   val = 32'h00000029;
            5'd25:   val = 32'h00000014;
            5'd26:   val = 32'h0000000A;
            5'd27:   val = 32'h00000005;
            5'd28:   val = 32'h00000003;
            5'd29:   val = 32'h00000001;
            5'd30:   val = 32'h00000001;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

    // Round Q30 half up to Q1.15 and saturate.
    function automatic logic [15:0] to_q15(input cord_t v);
        cord_t t;
        cord_t s;
        logic [15:0] res;
        t = v + cord_t'(16384);
        s = t >>> 15;
        if (s > cord_t'(32767))
            res = 16'h7FFF;
        else if (s < -cord_t'(32768))
            res = 16'h8000;
        else
            res = s[15:0];
        return res;
    endfunction

endpackage

// ----- design/concentric_square_to_disk_map.sv -----
// Concentric square-to-disk mapper: sector split, pipelined ratio divider, CORDIC rotator.
`timescale 1ns / 1ps
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+------------------------
//  sample  | sample_valid | sample_stall | sample_u, sample_v
//  disk    | disk_valid   | disk_stall   | disk_x, disk_y
//
// One request enters per cycle unless sample_stall is high; the stages are front,
// 30 divider bit stages, angle/gain, quadrant, one per CORDIC stage, output.
// The restoring divider sets the depth: one quotient bit per stage.
// Reset clears only the valid bits; payload registers carry no reset.
// Each stage holds while its successor is full and held, so a bubble is
// squeezed out and a stalled result keeps the rest of the pipe filling.
module concentric_square_to_disk_map
    import csdm_pkg::*;
#(
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int ROTATION_STAGES = ROT_STAGES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  logic [15:0] sample_u,
    input  logic [15:0] sample_v,
    output logic        disk_valid,
    input  logic        disk_stall,
    output logic [15:0] disk_x,
    output logic [15:0] disk_y
);

    localparam int CW     = COORD_BITS;
    localparam int NS     = ROTATION_STAGES;
    localparam int ST_M   = DIV_BITS + 1;
    localparam int ST_Q   = DIV_BITS + 2;
    localparam int ST_C0  = DIV_BITS + 3;
    localparam int ST_OUT = ST_C0 + NS;
    localparam int NST    = ST_OUT + 1;

    // ---------------- pipeline control ----------------
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !valid_reg[NST-1] || !disk_stall;
        for (int j = NST - 2; j >= 0; j--)
        begin
            en[j] = !valid_reg[j] || en[j+1];
        end
    end

    assign sample_stall = !en[0];
    assign disk_valid   = valid_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
                valid_reg[0] <= sample_valid;
            for (int j = 1; j < NST; j++)
            begin
                if (en[j])
                    valid_reg[j] <= valid_reg[j-1];
            end
        end
    end

    // ---------------- front: map to [-1,1], pick sector ----------------
    // Divider stage arrays, index 0 is the front register.
    logic [CW+1:0]       rem_reg  [0:DIV_BITS];
    logic [CW+1:0]       rem_next [0:DIV_BITS];
    logic [CW:0]         den_reg  [0:DIV_BITS];
    logic [CW:0]         den_next [0:DIV_BITS];
    logic [DIV_BITS-1:0] quo_reg  [0:DIV_BITS];
    logic [DIV_BITS-1:0] quo_next [0:DIV_BITS];
    logic                neg_reg  [0:DIV_BITS];
    logic                neg_next [0:DIV_BITS];
    logic [1:0]          sec_reg  [0:DIV_BITS];
    logic [1:0]          sec_next [0:DIV_BITS];

    logic [CW-1:0]        u_c;
    logic [CW-1:0]        v_c;
    logic signed [CW+1:0] a_s;
    logic signed [CW+1:0] b_s;
    logic signed [CW+1:0] na_s;
    logic signed [CW+1:0] nb_s;
    logic [CW:0]          abs_a;
    logic [CW:0]          abs_b;

    // Bits above COORD_BITS drop; a narrower port zero-extends.
    assign u_c  = CW'(sample_u);
    assign v_c  = CW'(sample_v);
    assign a_s  = $signed({1'b0, u_c, 1'b0}) - $signed({2'b01, {CW{1'b0}}});
    assign b_s  = $signed({1'b0, v_c, 1'b0}) - $signed({2'b01, {CW{1'b0}}});
    assign na_s = -a_s;
    assign nb_s = -b_s;
    assign abs_a = a_s[CW+1] ? na_s[CW:0] : a_s[CW:0];
    assign abs_b = b_s[CW+1] ? nb_s[CW:0] : b_s[CW:0];

    // The divisor is the radius in every sector; numerator magnitude never
    // exceeds it, so the ratio magnitude is at most one octant.
    always_comb
    begin
        if (a_s > nb_s)
        begin
            if (a_s > b_s)
            begin
                sec_next[0] = SEC_EAST;
                den_next[0] = a_s[CW:0];
                rem_next[0] = {1'b0, abs_b};
                neg_next[0] = b_s[CW+1];
            end
            else
            begin
                sec_next[0] = SEC_NORTH;
                den_next[0] = b_s[CW:0];
                rem_next[0] = {1'b0, abs_a};
                neg_next[0] = !a_s[CW+1] && (a_s != '0);
            end
        end
        else
        begin
            if (a_s < b_s)
            begin
                sec_next[0] = SEC_WEST;
                den_next[0] = na_s[CW:0];
                rem_next[0] = {1'b0, abs_b};
                neg_next[0] = !b_s[CW+1] && (b_s != '0);
            end
            else
            begin
                // Origin lands here with r = 0, so its angle is irrelevant.
                sec_next[0] = SEC_SOUTH;
                den_next[0] = nb_s[CW:0];
                rem_next[0] = {1'b0, abs_a};
                neg_next[0] = a_s[CW+1];
            end
        end
        quo_next[0] = '0;
    end

    // ---------------- restoring divider, one quotient bit per stage ----------------
    // First step compares without doubling (numerator may equal the divisor),
    // later steps double the partial remainder first.
    for (genvar k = 1; k <= DIV_BITS; k++)
    begin : g_div
        logic [CW+1:0] trial;
        logic          ge;
        if (k == 1)
        begin : g_first
            assign trial = rem_reg[k-1];
        end
        else
        begin : g_rest
            assign trial = {rem_reg[k-1][CW:0], 1'b0};
        end
        assign ge          = trial >= {1'b0, den_reg[k-1]};
        assign rem_next[k] = ge ? (trial - {1'b0, den_reg[k-1]}) : trial;
        assign den_next[k] = den_reg[k-1];
        assign neg_next[k] = neg_reg[k-1];
        assign sec_next[k] = sec_reg[k-1];
        always_comb
        begin
            quo_next[k]             = quo_reg[k-1];
            quo_next[k][DIV_BITS-k] = ge;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= DIV_BITS; k++)
        begin
            if (en[k])
            begin
                rem_reg[k] <= rem_next[k];
                den_reg[k] <= den_next[k];
                quo_reg[k] <= quo_next[k];
                neg_reg[k] <= neg_next[k];
                sec_reg[k] <= sec_next[k];
            end
        end
    end

    // ---------------- angle assembly and gain-compensated radius ----------------
    logic [30:0]          rq;
    logic [61:0]          prod;
    logic [31:0]          qext;
    logic [ANG_BITS-1:0]  ang_reg;
    logic [ANG_BITS-1:0]  ang_next;
    logic [RAD_BITS-1:0]  rad_reg;
    logic [RAD_BITS-1:0]  rad_next;

    if (CW <= 30)
    begin : g_rq_up
        assign rq = 31'(den_reg[DIV_BITS]) << (30 - CW);
    end
    else
    begin : g_rq_dn
        assign rq = 31'(den_reg[DIV_BITS] >> (CW - 30));
    end

    assign prod     = 62'(rq) * 62'(GAIN_COMP);
    assign rad_next = prod[60:31];
    assign qext     = {2'b00, quo_reg[DIV_BITS]};
    // Offset is sector times two octants, ratio added or taken off.
    assign ang_next = {sec_reg[DIV_BITS], 30'b0}
                    + (neg_reg[DIV_BITS] ? (~qext + 32'd1) : qext);

    always_ff @(posedge clk)
    begin
        if (en[ST_M])
        begin
            ang_reg <= ang_next;
            rad_reg <= rad_next;
        end
    end

    // ---------------- quadrant fold, CORDIC start vector ----------------
    cord_t              x_reg  [0:NS];
    cord_t              x_next [0:NS];
    cord_t              y_reg  [0:NS];
    cord_t              y_next [0:NS];
    logic signed [31:0] z_reg  [0:NS];
    logic signed [31:0] z_next [0:NS];

    logic [31:0] qsum;
    logic [1:0]  quad;
    cord_t       rad_s;

    assign qsum      = ang_reg + HALF_QUAD;
    assign quad      = qsum[31:30];
    assign rad_s     = cord_t'({1'b0, rad_reg});
    assign z_next[0] = $signed(ang_reg - {quad, 30'b0});

    always_comb
    begin
        case (quad)
            QUAD_0:
            begin
                x_next[0] = rad_s;
                y_next[0] = '0;
            end
            QUAD_1:
            begin
                x_next[0] = '0;
                y_next[0] = rad_s;
            end
            QUAD_2:
            begin
                x_next[0] = -rad_s;
                y_next[0] = '0;
            end
            default:
            begin
                x_next[0] = '0;
                y_next[0] = -rad_s;
            end
        endcase
    end

    // ---------------- CORDIC rotation stages ----------------
    for (genvar i = 0; i < NS; i++)
    begin : g_cord
        cord_t       dx;
        cord_t       dy;
        logic [31:0] at;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign at = atan_bam(5'(i));
        assign x_next[i+1] = z_reg[i][31] ? (x_reg[i] + dx) : (x_reg[i] - dx);
        assign y_next[i+1] = z_reg[i][31] ? (y_reg[i] - dy) : (y_reg[i] + dy);
        assign z_next[i+1] = z_reg[i][31] ? (z_reg[i] + $signed(at))
                                          : (z_reg[i] - $signed(at));
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= NS; i++)
        begin
            if (en[ST_Q + i])
            begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
            end
        end
    end

    // ---------------- round to Q1.15 and saturate ----------------
    logic [15:0] disk_x_reg;
    logic [15:0] disk_x_next;
    logic [15:0] disk_y_reg;
    logic [15:0] disk_y_next;

    assign disk_x_next = to_q15(x_reg[NS]);
    assign disk_y_next = to_q15(y_reg[NS]);

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            disk_x_reg <= disk_x_next;
            disk_y_reg <= disk_y_next;
        end
    end

    assign disk_x = disk_x_reg;
    assign disk_y = disk_y_reg;

endmodule

// ----- verif/csdm_checker.sv -----
// Checker for the square-to-disk mapper: watches both channels, predicts disk points, compares.
`timescale 1ns / 1ps
module csdm_checker
    import csdm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    input  logic        sample_stall,
    input  logic [15:0] sample_u,
    input  logic [15:0] sample_v,
    input  logic        disk_valid,
    input  logic        disk_stall,
    input  logic [15:0] disk_x,
    input  logic [15:0] disk_y,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
    } disk_pt_t;

    // Ring of predicted points; far deeper than the pipeline can hold in flight.
    localparam int EXP_DEPTH = 128;

    disk_pt_t exp_mem [0:EXP_DEPTH-1];
    int       wr_cnt;
    int       rd_cnt;

    localparam logic [31:0] ATAN_TBL [0:15] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    function automatic logic [15:0] round_sat(input longint v);
        longint q;
        q = (v + 16384) >>> 15;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    function automatic disk_pt_t map_to_disk(input logic [15:0] u, input logic [15:0] v);
        longint a;
        longint b;
        longint r;
        longint ang;
        longint rq;
        longint x;
        longint y;
        longint z;
        longint t;
        logic [31:0] phi;
        logic [31:0] res;
        logic [1:0] quad;
        disk_pt_t pt;
        a = 2 * longint'(u) - 65536;
        b = 2 * longint'(v) - 65536;
        ang = 0;
        if (a > -b)
        begin
            if (a > b)
            begin
                r = a;
                ang = (b * 536870912) / a;
            end
            else
            begin
                r = b;
                ang = 2 * 536870912 - (a * 536870912) / b;
            end
        end
        else if (a < b)
        begin
            r = -a;
            ang = 4 * 536870912 + (b * 536870912) / a;
        end
        else
        begin
            r = -b;
            if (b != 0)
                ang = 6 * 536870912 - (a * 536870912) / b;
        end
        phi = ang[31:0];
        rq = ((r <<< 14) * 1304065748) >>> 31;
        quad = 2'((phi + HALF_QUAD) >> 30);
        res = phi - {quad, 30'd0};
        z = longint'($signed(res));
        case (quad)
            QUAD_0:
            begin
                x = rq;
                y = 0;
            end
            QUAD_1:
            begin
                x = 0;
                y = rq;
            end
            QUAD_2:
            begin
                x = -rq;
                y = 0;
            end
            default:
            begin
                x = 0;
                y = -rq;
            end
        endcase
        for (int i = 0; i < 16; i++)
        begin
            if (z >= 0)
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(ATAN_TBL[i]);
            end
            else
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(ATAN_TBL[i]);
            end
            x = t;
        end
        pt.x = round_sat(x);
        pt.y = round_sat(y);
        return pt;
    endfunction

    assign pending = wr_cnt - rd_cnt;

    always @(posedge clk or negedge rst_n)
    begin
        disk_pt_t want;
        int       errs;
        if (!rst_n)
        begin
            fail_count <= 0;
            wr_cnt     <= 0;
            rd_cnt     <= 0;
        end
        else
        begin
            errs = 0;
            if (sample_valid && !sample_stall)
            begin
                exp_mem[wr_cnt[6:0]] <= map_to_disk(sample_u, sample_v);
                wr_cnt <= wr_cnt + 1;
            end
            if (disk_valid && !disk_stall)
            begin
                if (wr_cnt == rd_cnt)
                begin
                    $error("unexpected disk point x=%0d y=%0d",
                           $signed(disk_x), $signed(disk_y));
                    errs = errs + 1;
                end
                else
                begin
                    want = exp_mem[rd_cnt[6:0]];
                    rd_cnt <= rd_cnt + 1;
                    if (want.x !== disk_x)
                    begin
                        $error("disk_x expected %0d actual %0d",
                               $signed(want.x), $signed(disk_x));
                        errs = errs + 1;
                    end
                    if (want.y !== disk_y)
                    begin
                        $error("disk_y expected %0d actual %0d",
                               $signed(want.y), $signed(disk_y));
                        errs = errs + 1;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end

endmodule

// ----- verif/tb_top.sv -----
// Testbench top for the square-to-disk mapper: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
    import csdm_pkg::*;

    localparam int NUM_RANDOM  = 1600;
    localparam int CALM_TAIL   = 200;
    localparam int DRAIN_WAIT  = 80;
    localparam int CYCLE_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        sample_valid;
    logic        sample_stall;
    logic [15:0] sample_u;
    logic [15:0] sample_v;
    logic        disk_valid;
    logic        disk_stall;
    logic [15:0] disk_x;
    logic [15:0] disk_y;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    bit          calm;

    // Directed requests: corners, edges, origin, sector boundaries, diagonals.
    logic [15:0] dir_u[$] = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000,
                              16'h8000, 16'h8001, 16'h7FFF, 16'h8000, 16'h8000,
                              16'hC000, 16'h4000, 16'h4000, 16'hC000, 16'hFFFF,
                              16'h0000, 16'h8000, 16'h8000, 16'hAAAA, 16'h5555,
                              16'h0001, 16'hFFFE};
    logic [15:0] dir_v[$] = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h8000,
                              16'h8001, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000,
                              16'hC000, 16'hC000, 16'h4000, 16'h4000, 16'h8000,
                              16'h8000, 16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA,
                              16'hFFFE, 16'h0001};

    concentric_square_to_disk_map u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_u     (sample_u),
        .sample_v     (sample_v),
        .disk_valid   (disk_valid),
        .disk_stall   (disk_stall),
        .disk_x       (disk_x),
        .disk_y       (disk_y)
    );

    csdm_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_u     (sample_u),
        .sample_v     (sample_v),
        .disk_valid   (disk_valid),
        .disk_stall   (disk_stall),
        .disk_x       (disk_x),
        .disk_y       (disk_y),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Watchdog: a hung pipe ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver stall: random bursts, none once the run goes calm.
    initial
    begin
        int burst;
        disk_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 6);
                disk_stall <= 1'b1;
                repeat (burst) @(posedge clk);
            end
            disk_stall <= 1'b0;
        end
    end

    // Present one request and hold it until accepted.
    task automatic send_sample(input logic [15:0] u, input logic [15:0] v);
        sample_valid <= 1'b1;
        sample_u     <= u;
        sample_v     <= v;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
    endtask

    // Drop valid for a random burst; skipped entirely in the calm tail.
    task automatic maybe_idle();
        int burst;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            burst = $urandom_range(1, 6);
            sample_valid <= 1'b0;
            sample_u     <= 16'($urandom);
            sample_v     <= 16'($urandom);
            repeat (burst) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [15:0] u;
        logic [15:0] v;
        calm         = 1'b0;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample_u     = '0;
        sample_v     = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_u[i])
        begin
            send_sample(dir_u[i], dir_v[i]);
            maybe_idle();
        end

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (n == NUM_RANDOM - CALM_TAIL)
                calm = 1'b1;
            // Mostly uniform samples; some near the center and on the diagonals.
            case ($urandom_range(0, 5))
                0:
                begin
                    u = 16'h8000 + 16'($urandom_range(0, 15)) - 16'd8;
                    v = 16'h8000 + 16'($urandom_range(0, 15)) - 16'd8;
                end
                1:
                begin
                    u = 16'($urandom);
                    v = ($urandom_range(0, 1) != 0) ? u : 16'hFFFF - u + 16'd1;
                end
                default:
                begin
                    u = 16'($urandom);
                    v = 16'($urandom);
                end
            endcase
            send_sample(u, v);
            maybe_idle();
        end
        sample_valid <= 1'b0;

        // Drain, then allow a full pipeline depth for stray results.
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
